>>> design/obq_pkg.sv
// shared types, constants and fixed-point helpers of the oriented box query engine
`timescale 1ns / 1ps
package obq_pkg;

   localparam int FRACTION_BITS_DEF = 16;
   localparam int QUEUE_DEPTH_DEF   = 4;

   localparam int NRM_BITS = 14;   // fraction bits of sine, cosine and normals
   localparam int NW       = 17;   // normal width, holds the negated extremes
   localparam int PTW      = 40;   // edge point and bound width
   localparam int OPW      = 44;   // dot product operand width
   localparam int MAGW     = 56;   // divider operand width

   localparam logic [1:0] OP_POINT  = 2'd0;
   localparam logic [1:0] OP_CIRCLE = 2'd1;
   localparam logic [1:0] OP_RAY    = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [2:0] REG_CENTER_X    = 3'd0;
   localparam logic [2:0] REG_CENTER_Y    = 3'd1;
   localparam logic [2:0] REG_HALF_WIDTH  = 3'd2;
   localparam logic [2:0] REG_HALF_HEIGHT = 3'd3;
   localparam logic [2:0] REG_FACING_SIN  = 3'd4;
   localparam logic [2:0] REG_FACING_COS  = 3'd5;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [30:0]        radius;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
   } item_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] push_x;
      logic signed [31:0] push_y;
      logic [31:0]        ray_distance;
   } result_type;

   typedef struct packed {
      logic                 busy;
      logic [3:0][NW-1:0]   nx;
      logic [3:0][NW-1:0]   ny;
      logic [3:0][PTW-1:0]  epx;
      logic [3:0][PTW-1:0]  epy;
      logic [PTW-1:0]       min_x;
      logic [PTW-1:0]       min_y;
      logic [PTW-1:0]       max_x;
      logic [PTW-1:0]       max_y;
   } geom_type;

   // shift right by k, round to nearest, ties away from zero
   function automatic logic signed [63:0] rshr(input logic signed [63:0] x, input int k);
      logic [63:0] m;
      m = x[63] ? (64'd0 - x) : x;
      m = (m + (64'd1 << (k - 1))) >> k;
      return x[63] ? $signed(64'd0 - m) : $signed(m);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end
      if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

endpackage

>>> design/obq_csr.sv
// configuration registers and the sequencer that derives edges and bounds from them
`timescale 1ns / 1ps
module obq_csr import obq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output geom_type    geom
);

   logic [31:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [30:0] hw_ff, hw_in, hh_ff, hh_in;
   logic [15:0] sin_ff, sin_in, cos_ff, cos_in;
   logic [3:0]  dstep_ff, dstep_in;

   logic signed [PTW-1:0] epx_ff [4];
   logic signed [PTW-1:0] epy_ff [4];
   logic signed [PTW-1:0] minx_ff, minx_in, miny_ff, miny_in;
   logic signed [PTW-1:0] maxx_ff, maxx_in, maxy_ff, maxy_in;
   logic signed [PTW-1:0] epx_in, epy_in;

   logic                  wr;
   logic [2:0]            idx;
   logic signed [NW-1:0]  s, c, ns, nc;
   logic [3:0][NW-1:0]    nx, ny;
   logic [1:0]            k, j;
   logic                  phase;
   logic [30:0]           e;
   logic signed [48:0]    prx, pry;
   logic signed [63:0]    sumx, sumy;

   assign wr     = psel & penable & pwrite;
   assign idx    = paddr[4:2];
   assign pready = 1'b1;

   always_comb begin
      cx_in  = cx_ff;
      cy_in  = cy_ff;
      hw_in  = hw_ff;
      hh_in  = hh_ff;
      sin_in = sin_ff;
      cos_in = cos_ff;
      if (wr) begin
         unique case (idx)
            REG_CENTER_X:    cx_in  = pwdata;
            REG_CENTER_Y:    cy_in  = pwdata;
            REG_HALF_WIDTH:  hw_in  = pwdata[30:0];
            REG_HALF_HEIGHT: hh_in  = pwdata[30:0];
            REG_FACING_SIN:  sin_in = pwdata[15:0];
            REG_FACING_COS:  cos_in = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_CENTER_X:    prdata = cx_ff;
         REG_CENTER_Y:    prdata = cy_ff;
         REG_HALF_WIDTH:  prdata = {1'b0, hw_ff};
         REG_HALF_HEIGHT: prdata = {1'b0, hh_ff};
         REG_FACING_SIN:  prdata = {16'd0, sin_ff};
         REG_FACING_COS:  prdata = {16'd0, cos_ff};
         default:         prdata = 32'd0;
      endcase
   end

   // normals n0=(s,-c) n1=(-s,c) n2=(-c,-s) n3=(c,s)
   always_comb begin
      s  = $signed({sin_ff[15], sin_ff});
      c  = $signed({cos_ff[15], cos_ff});
      ns = -s;
      nc = -c;
      nx = {c, nc, ns, s};
      ny = {s, ns, c, nc};
   end

   // steps 0..3 place edge points, 4..7 walk the corners
   always_comb begin
      k     = dstep_ff[1:0];
      phase = dstep_ff[2];
      j     = phase ? k + 2'd2 : k;
      if (phase) begin
         e = k[1] ? hh_ff : hw_ff;
      end else begin
         e = k[1] ? hw_ff : hh_ff;
      end
      prx = $signed(nx[j]) * $signed({1'b0, e});
      pry = $signed(ny[j]) * $signed({1'b0, e});
      if (phase) begin
         sumx = 64'(epx_ff[k]) + rshr(64'(prx), NRM_BITS);
         sumy = 64'(epy_ff[k]) + rshr(64'(pry), NRM_BITS);
      end else begin
         sumx = 64'($signed(cx_ff)) + rshr(64'(prx), NRM_BITS);
         sumy = 64'($signed(cy_ff)) + rshr(64'(pry), NRM_BITS);
      end
      epx_in  = sumx[PTW-1:0];
      epy_in  = sumy[PTW-1:0];
      minx_in = minx_ff;
      miny_in = miny_ff;
      maxx_in = maxx_ff;
      maxy_in = maxy_ff;
      if (phase) begin
         if (k == 2'd0 || epx_in < minx_ff) minx_in = epx_in;
         if (k == 2'd0 || epy_in < miny_ff) miny_in = epy_in;
         if (k == 2'd0 || epx_in > maxx_ff) maxx_in = epx_in;
         if (k == 2'd0 || epy_in > maxy_ff) maxy_in = epy_in;
      end
      if (wr) begin
         dstep_in = 4'd0;
      end else if (!dstep_ff[3]) begin
         dstep_in = dstep_ff + 4'd1;
      end else begin
         dstep_in = dstep_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff    <= 32'd0;
         cy_ff    <= 32'd0;
         hw_ff    <= 31'd0;
         hh_ff    <= 31'd0;
         sin_ff   <= 16'd0;
         cos_ff   <= 16'd16384;
         dstep_ff <= 4'd0;
      end else begin
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
         hw_ff    <= hw_in;
         hh_ff    <= hh_in;
         sin_ff   <= sin_in;
         cos_ff   <= cos_in;
         dstep_ff <= dstep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!dstep_ff[3]) begin
         if (!phase) begin
            epx_ff[k] <= epx_in;
            epy_ff[k] <= epy_in;
         end
         minx_ff <= minx_in;
         miny_ff <= miny_in;
         maxx_ff <= maxx_in;
         maxy_ff <= maxy_in;
      end
   end

   always_comb begin
      geom.busy  = !dstep_ff[3];
      geom.nx    = nx;
      geom.ny    = ny;
      for (int n = 0; n < 4; n++) begin
         geom.epx[n] = epx_ff[n];
         geom.epy[n] = epy_ff[n];
      end
      geom.min_x = minx_ff;
      geom.min_y = miny_ff;
      geom.max_x = maxx_ff;
      geom.max_y = maxy_ff;
   end

endmodule

>>> design/obq_front.sv
// front end: takes query items and queues them for the back end
`timescale 1ns / 1ps
module obq_front import obq_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  item_type    req,
   input  logic        hold,
   output logic        busy,
   output logic        q_valid,
   output item_type    q_item,
   input  logic        q_pop
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   item_type        mem_ff [QUEUE_DEPTH];
   logic [AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            full, push, pop;
   item_type        entry;

   assign full    = (cnt_ff == CW'(QUEUE_DEPTH));
   assign busy    = full | hold;
   assign push    = start & !busy;
   assign q_valid = (cnt_ff != '0);
   assign pop     = q_pop & q_valid;
   assign q_item  = mem_ff[rd_ff];

   // an unused operation code is folded to one class that yields an all-zero result
   always_comb begin
      entry = req;
      if (req.operation == OP_UNUSED) begin
         entry.operation = OP_UNUSED;
      end
   end

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      cnt_in = cnt_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= entry;
      end
   end

endmodule

>>> design/obq_div.sv
// bit-serial divider giving floor(num * 2^F / den), saturating at all ones
`timescale 1ns / 1ps
module obq_div import obq_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            go,
   input  logic [MAGW-1:0] num,
   input  logic [MAGW-1:0] den,
   output logic            done,
   output logic [31:0]     quot
);

   localparam int DIVW = MAGW + 33;

   logic [DIVW-1:0] rem_ff, rem_in, dsh_ff, dsh_in;
   logic [31:0]     quot_ff, quot_in;
   logic [4:0]      cnt_ff, cnt_in;
   logic            run_ff, run_in, done_ff, done_in;
   logic [DIVW-1:0] nsh;
   logic            ge;

   always_comb begin
      nsh     = DIVW'(num) << FRACTION_BITS;
      ge      = (rem_ff >= dsh_ff);
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (go) begin
         rem_in = nsh;
         dsh_in = DIVW'(den) << 31;
         cnt_in = 5'd31;
         if (nsh >= (DIVW'(den) << 32)) begin
            quot_in = 32'hFFFFFFFF;
            done_in = 1'b1;
         end else begin
            quot_in = 32'd0;
            run_in  = 1'b1;
         end
      end else if (run_ff) begin
         if (ge) begin
            rem_in = rem_ff - dsh_ff;
         end
         quot_in = {quot_ff[30:0], ge};
         dsh_in  = dsh_ff >> 1;
         cnt_in  = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

>>> design/obq_back.sv
// back end: runs one queued query at a time over a shared dot product unit
`timescale 1ns / 1ps
module obq_back import obq_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  item_type   q_item,
   output logic       q_pop,
   input  geom_type   geom,
   output logic       rsp_valid,
   output result_type rsp
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_BOUND = 4'd1;
   localparam logic [3:0] S_EDGE  = 4'd2;
   localparam logic [3:0] S_PUSH  = 4'd3;
   localparam logic [3:0] S_RQ    = 4'd4;
   localparam logic [3:0] S_RNUM  = 4'd5;
   localparam logic [3:0] S_RDIV  = 4'd6;
   localparam logic [3:0] S_RADVX = 4'd7;
   localparam logic [3:0] S_RADVY = 4'd8;
   localparam logic [3:0] S_RCHK1 = 4'd9;
   localparam logic [3:0] S_RCHK2 = 4'd10;
   localparam logic [3:0] S_DONE  = 4'd11;

   localparam logic [63:0] RAY_EPS =
      ((64'd1 << (FRACTION_BITS + NRM_BITS)) + 64'd999999) / 64'd1000000;
   localparam logic signed [59:0] FAR_LIMIT = 60'sd1 <<< 40;

   logic [3:0]         state_ff, state_in;
   item_type           it_ff, it_in;
   logic [1:0]         i_ff, i_in, bi_ff, bi_in;
   logic               hit_ff, hit_in;
   logic signed [63:0] best_ff, best_in;
   logic signed [31:0] pushx_ff, pushx_in, pushy_ff, pushy_in;
   logic [31:0]        dist_ff, dist_in, t_ff, t_in;
   logic               qneg_ff, qneg_in;
   logic [MAGW-1:0]    aq_ff, aq_in;
   logic signed [59:0] lx_ff, lx_in, ly_ff, ly_in;
   logic               rspv_ff, rspv_in;
   result_type         rsp_ff, rsp_in;

   logic signed [OPW-1:0]    ax, ay;
   logic [1:0]               nsel, jb;
   logic signed [OPW+NW-1:0] prod_x, prod_y;
   logic signed [63:0]       dv, dc;
   logic [63:0]              absdv, radv;
   logic signed [OPW-1:0]    pxe, pye, rads, bminx, bminy, bmaxx, bmaxy;
   logic                     inbox, overlap;
   logic signed [63:0]       dfr;
   logic signed [39:0]       dfn;
   logic signed [56:0]       ppx, ppy;
   logic [31:0]              mag;
   logic                     dneg;
   logic [63:0]              tm, madv;
   logic signed [59:0]       start_pos, adv;
   logic                     far;
   logic                     div_go, div_done;
   logic [31:0]              div_quot;

   obq_div #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .go(div_go),
      .num(absdv[MAGW-1:0]),
      .den(aq_ff),
      .done(div_done),
      .quot(div_quot)
   );

   // dot product unit: operands picked by state
   always_comb begin
      jb = i_ff[1] ? 2'd0 : 2'd2;
      unique case (state_ff)
         S_EDGE: begin
            ax   = OPW'(it_ff.pos_x) - OPW'($signed(geom.epx[i_ff]));
            ay   = OPW'(it_ff.pos_y) - OPW'($signed(geom.epy[i_ff]));
            nsel = i_ff;
         end
         S_RQ: begin
            ax   = OPW'(it_ff.dir_x);
            ay   = OPW'(it_ff.dir_y);
            nsel = i_ff;
         end
         S_RNUM: begin
            ax   = OPW'($signed(geom.epx[i_ff])) - OPW'(it_ff.pos_x);
            ay   = OPW'($signed(geom.epy[i_ff])) - OPW'(it_ff.pos_y);
            nsel = i_ff;
         end
         S_RCHK1: begin
            ax   = OPW'(lx_ff) - OPW'($signed(geom.epx[jb]));
            ay   = OPW'(ly_ff) - OPW'($signed(geom.epy[jb]));
            nsel = jb;
         end
         S_RCHK2: begin
            ax   = OPW'(lx_ff) - OPW'($signed(geom.epx[{jb[1], 1'b1}]));
            ay   = OPW'(ly_ff) - OPW'($signed(geom.epy[{jb[1], 1'b1}]));
            nsel = {jb[1], 1'b1};
         end
         default: begin
            ax   = '0;
            ay   = '0;
            nsel = i_ff;
         end
      endcase
      prod_x = ax * $signed(geom.nx[nsel]);
      prod_y = ay * $signed(geom.ny[nsel]);
      dv     = 64'(prod_x) + 64'(prod_y);
      absdv  = dv[63] ? (64'd0 - dv) : dv;
      radv   = 64'(it_ff.radius) << NRM_BITS;
      dc     = dv - $signed(radv);
   end

   // bounding box tests
   always_comb begin
      pxe     = OPW'(it_ff.pos_x);
      pye     = OPW'(it_ff.pos_y);
      rads    = $signed(OPW'(it_ff.radius));
      bminx   = OPW'($signed(geom.min_x));
      bminy   = OPW'($signed(geom.min_y));
      bmaxx   = OPW'($signed(geom.max_x));
      bmaxy   = OPW'($signed(geom.max_y));
      inbox   = pxe >= bminx && pxe <= bmaxx && pye >= bminy && pye <= bmaxy;
      overlap = bminx <= pxe + rads && pxe - rads <= bmaxx &&
                bminy <= pye + rads && pye - rads <= bmaxy;
   end

   // penetration vector and ray advance
   always_comb begin
      dfr = rshr(best_ff, NRM_BITS);
      dfn = dfr[39:0];
      ppx = dfn * $signed(geom.nx[bi_ff]);
      ppy = dfn * $signed(geom.ny[bi_ff]);
      if (state_ff == S_RADVY) begin
         dneg      = it_ff.dir_y[31];
         mag       = dneg ? (32'd0 - it_ff.dir_y) : it_ff.dir_y;
         start_pos = 60'(it_ff.pos_y);
      end else begin
         dneg      = it_ff.dir_x[31];
         mag       = dneg ? (32'd0 - it_ff.dir_x) : it_ff.dir_x;
         start_pos = 60'(it_ff.pos_x);
      end
      tm   = 64'(t_ff) * 64'(mag);
      madv = (tm + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
      adv  = dneg ? start_pos - $signed(madv[59:0]) : start_pos + $signed(madv[59:0]);
      far  = lx_ff > FAR_LIMIT || lx_ff < -FAR_LIMIT ||
             ly_ff > FAR_LIMIT || ly_ff < -FAR_LIMIT;
   end

   always_comb begin
      state_in = state_ff;
      it_in    = it_ff;
      i_in     = i_ff;
      bi_in    = bi_ff;
      hit_in   = hit_ff;
      best_in  = best_ff;
      pushx_in = pushx_ff;
      pushy_in = pushy_ff;
      dist_in  = dist_ff;
      t_in     = t_ff;
      qneg_in  = qneg_ff;
      aq_in    = aq_ff;
      lx_in    = lx_ff;
      ly_in    = ly_ff;
      rspv_in  = 1'b0;
      rsp_in   = rsp_ff;
      q_pop    = 1'b0;
      div_go   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               it_in    = q_item;
               i_in     = 2'd0;
               hit_in   = 1'b0;
               pushx_in = 32'sd0;
               pushy_in = 32'sd0;
               dist_in  = 32'd0;
               state_in = S_BOUND;
            end
         end
         S_BOUND: begin
            case (it_ff.operation)
               OP_POINT: begin
                  hit_in   = inbox;
                  state_in = inbox ? S_EDGE : S_DONE;
               end
               OP_CIRCLE: begin
                  hit_in   = overlap;
                  state_in = overlap ? S_EDGE : S_DONE;
               end
               OP_RAY:    state_in = S_RQ;
               OP_UNUSED: state_in = S_DONE;
            endcase
         end
         S_EDGE: begin
            if (it_ff.operation == OP_POINT) begin
               if (dv > 64'sd0) begin
                  hit_in   = 1'b0;
                  state_in = S_DONE;
               end else if (i_ff == 2'd3) begin
                  state_in = S_DONE;
               end else begin
                  i_in = i_ff + 2'd1;
               end
            end else begin
               if (dc > 64'sd0) begin
                  hit_in   = 1'b0;
                  state_in = S_DONE;
               end else begin
                  // strict compare keeps the first edge on a tie
                  if (i_ff == 2'd0 || dc > best_ff) begin
                     best_in = dc;
                     bi_in   = i_ff;
                  end
                  if (i_ff == 2'd3) begin
                     state_in = S_PUSH;
                  end else begin
                     i_in = i_ff + 2'd1;
                  end
               end
            end
         end
         S_PUSH: begin
            pushx_in = sat32(rshr(64'(ppx), NRM_BITS));
            pushy_in = sat32(rshr(64'(ppy), NRM_BITS));
            state_in = S_DONE;
         end
         S_RQ: begin
            qneg_in = dv[63];
            aq_in   = absdv[MAGW-1:0];
            if (absdv < RAY_EPS) begin
               state_in = (i_ff == 2'd3) ? S_DONE : S_RQ;
               i_in     = i_ff + 2'd1;
            end else begin
               state_in = S_RNUM;
            end
         end
         S_RNUM: begin
            // hit behind the start
            if (dv != 64'sd0 && dv[63] != qneg_ff) begin
               state_in = (i_ff == 2'd3) ? S_DONE : S_RQ;
               i_in     = i_ff + 2'd1;
            end else begin
               div_go   = 1'b1;
               state_in = S_RDIV;
            end
         end
         S_RDIV: begin
            if (div_done) begin
               t_in     = div_quot;
               state_in = S_RADVX;
            end
         end
         S_RADVX: begin
            lx_in    = adv;
            state_in = S_RADVY;
         end
         S_RADVY: begin
            ly_in    = adv;
            state_in = S_RCHK1;
         end
         S_RCHK1: begin
            if (far || dv > 64'sd0) begin
               state_in = (i_ff == 2'd3) ? S_DONE : S_RQ;
               i_in     = i_ff + 2'd1;
            end else begin
               state_in = S_RCHK2;
            end
         end
         S_RCHK2: begin
            if (!(dv > 64'sd0) && (!hit_ff || t_ff < dist_ff)) begin
               dist_in = t_ff;
               hit_in  = 1'b1;
            end
            state_in = (i_ff == 2'd3) ? S_DONE : S_RQ;
            i_in     = i_ff + 2'd1;
         end
         S_DONE: begin
            rspv_in             = 1'b1;
            rsp_in.hit          = hit_ff;
            rsp_in.push_x       = pushx_ff;
            rsp_in.push_y       = pushy_ff;
            rsp_in.ray_distance = dist_ff;
            state_in            = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rspv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         rspv_ff  <= rspv_in;
      end
   end

   always_ff @(posedge clock) begin
      it_ff    <= it_in;
      i_ff     <= i_in;
      bi_ff    <= bi_in;
      hit_ff   <= hit_in;
      best_ff  <= best_in;
      pushx_ff <= pushx_in;
      pushy_ff <= pushy_in;
      dist_ff  <= dist_in;
      t_ff     <= t_in;
      qneg_ff  <= qneg_in;
      aq_ff    <= aq_in;
      lx_ff    <= lx_in;
      ly_ff    <= ly_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rspv_ff;
   assign rsp       = rsp_ff;

endmodule

>>> design/oriented_box_query_engine.sv
// top level of the oriented box query engine
//
//   channel   direction  handshake                    ports
//   request   in         start high while busy low    req_*
//   result    out        rsp_valid strobe, one cycle  rsp_*
//   config    in         apb write, pready tied high  psel penable pwrite paddr pwdata prdata
//
// a ray query runs the 32-step serial divider at most once per edge.
// the request queue takes new items while the back end works, so busy rises only when
// the queue is full or the edge and bound sequencer is running.
// that sequencer runs after reset and after each register write.
// results are never held: each strobe is taken in its own cycle.
`timescale 1ns / 1ps
module oriented_box_query_engine import obq_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF,
   parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_operation,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic [30:0]        req_radius,
   input  logic signed [31:0] req_dir_x,
   input  logic signed [31:0] req_dir_y,
   output logic               rsp_valid,
   output logic               rsp_hit,
   output logic signed [31:0] rsp_push_x,
   output logic signed [31:0] rsp_push_y,
   output logic [31:0]        rsp_ray_distance,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   geom_type   geom;
   item_type   req, q_item;
   logic       q_valid, q_pop;
   result_type rsp;

   always_comb begin
      req.operation = req_operation;
      req.pos_x     = req_pos_x;
      req.pos_y     = req_pos_y;
      req.radius    = req_radius;
      req.dir_x     = req_dir_x;
      req.dir_y     = req_dir_y;
   end

   obq_csr u_csr (
      .clock(clock),
      .reset(reset),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready),
      .geom(geom)
   );

   obq_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req(req),
      .hold(geom.busy),
      .busy(busy),
      .q_valid(q_valid),
      .q_item(q_item),
      .q_pop(q_pop)
   );

   obq_back #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_item(q_item),
      .q_pop(q_pop),
      .geom(geom),
      .rsp_valid(rsp_valid),
      .rsp(rsp)
   );

   assign rsp_hit          = rsp.hit;
   assign rsp_push_x       = rsp.push_x;
   assign rsp_push_y       = rsp.push_y;
   assign rsp_ray_distance = rsp.ray_distance;

endmodule

>>> tb/sv/tb_oriented_box_query_engine.sv
// self-checking testbench of the oriented box query engine
`timescale 1ns / 1ps
module tb_oriented_box_query_engine;
   import obq_pkg::*;

   localparam int FB = 16;
   localparam longint NEAR_ZERO = ((64'd1 << (FB + NRM_BITS)) + 999999) / 1000000;
   localparam longint FAR_EDGE = 64'sd1 << 40;
   localparam int IDLE_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_operation = OP_POINT;
   logic signed [31:0] req_pos_x = '0, req_pos_y = '0, req_dir_x = '0, req_dir_y = '0;
   logic [30:0] req_radius = '0;
   logic rsp_valid, rsp_hit;
   logic signed [31:0] rsp_push_x, rsp_push_y;
   logic [31:0] rsp_ray_distance;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [4:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   oriented_box_query_engine dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .req_radius(req_radius), .req_dir_x(req_dir_x), .req_dir_y(req_dir_y),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit), .rsp_push_x(rsp_push_x),
      .rsp_push_y(rsp_push_y), .rsp_ray_distance(rsp_ray_distance),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #10 clock = ~clock;

   // box model
   logic [31:0] box_reg [6];
   longint nrm_x [4], nrm_y [4], ept_x [4], ept_y [4], bnd [4];
   result_type expected_results [$];
   int items_sent = 0, results_checked = 0, mismatches = 0, idle_cycles = 0;
   int setups_used = 0;
   bit no_gaps = 1'b0;

   function automatic longint round_shift(longint x, int k);
      longint unsigned m;
      m = x < 0 ? longint'(0) - x : x;
      m = (m + (64'd1 << (k - 1))) >> k;
      return x < 0 ? longint'(0) - longint'(m) : longint'(m);
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint along_normal(longint ax, longint ay, int i);
      return ax * nrm_x[i] + ay * nrm_y[i];
   endfunction

   function automatic void rebuild_geometry();
      longint s, c, cx, cy, hw, hh, e, kx, ky;
      int j;
      s = longint'($signed(box_reg[REG_FACING_SIN][15:0]));
      c = longint'($signed(box_reg[REG_FACING_COS][15:0]));
      cx = longint'($signed(box_reg[REG_CENTER_X]));
      cy = longint'($signed(box_reg[REG_CENTER_Y]));
      hw = longint'(box_reg[REG_HALF_WIDTH][30:0]);
      hh = longint'(box_reg[REG_HALF_HEIGHT][30:0]);
      nrm_x[0] = s;  nrm_y[0] = -c;
      nrm_x[1] = -s; nrm_y[1] = c;
      nrm_x[2] = -c; nrm_y[2] = -s;
      nrm_x[3] = c;  nrm_y[3] = s;
      for (int i = 0; i < 4; i++) begin
         e = i < 2 ? hh : hw;
         ept_x[i] = cx + round_shift(nrm_x[i] * e, NRM_BITS);
         ept_y[i] = cy + round_shift(nrm_y[i] * e, NRM_BITS);
      end
      for (int i = 0; i < 4; i++) begin
         j = (i + 2) % 4;
         e = i < 2 ? hw : hh;
         kx = ept_x[i] + round_shift(nrm_x[j] * e, NRM_BITS);
         ky = ept_y[i] + round_shift(nrm_y[j] * e, NRM_BITS);
         if (i == 0 || kx < bnd[0]) bnd[0] = kx;
         if (i == 0 || ky < bnd[1]) bnd[1] = ky;
         if (i == 0 || kx > bnd[2]) bnd[2] = kx;
         if (i == 0 || ky > bnd[3]) bnd[3] = ky;
      end
   endfunction

   function automatic longint unsigned hit_time(longint unsigned a, longint unsigned b);
      longint unsigned ip, r, frac;
      ip = a / b;
      r = a % b;
      frac = 0;
      if (ip >= (64'd1 << (32 - FB))) return 64'hFFFF_FFFF;
      for (int k = 0; k < FB; k++) begin
         r = r << 1;
         frac = frac << 1;
         if (r >= b) begin
            r = r - b;
            frac = frac | 1;
         end
      end
      return (ip << FB) | frac;
   endfunction

   function automatic longint step_along(longint p, longint unsigned t, longint d);
      longint unsigned mag, m;
      mag = d < 0 ? longint'(0) - d : d;
      m = (t * mag + (64'd1 << (FB - 1))) >> FB;
      return d < 0 ? p - longint'(m) : p + longint'(m);
   endfunction

   function automatic result_type predict_query(item_type q);
      result_type r;
      longint px, py, rad, dx, dy, d, best, df, qd, num, lx, ly;
      longint unsigned aq, an, t, near_t;
      int bi, j;
      bit hit;
      px = q.pos_x; py = q.pos_y; rad = longint'(q.radius);
      dx = q.dir_x; dy = q.dir_y;
      hit = 0; near_t = 0; r = '0;
      case (q.operation)
         OP_POINT: begin
            if (px >= bnd[0] && px <= bnd[2] && py >= bnd[1] && py <= bnd[3]) begin
               hit = 1;
               for (int i = 0; i < 4; i++)
                  if (along_normal(px - ept_x[i], py - ept_y[i], i) > 0) hit = 0;
            end
         end
         OP_CIRCLE: begin
            if (bnd[0] <= px + rad && px - rad <= bnd[2] &&
                bnd[1] <= py + rad && py - rad <= bnd[3]) begin
               hit = 1; bi = -1; best = 0;
               for (int i = 0; i < 4; i++) begin
                  d = along_normal(px - ept_x[i], py - ept_y[i], i) - (rad <<< NRM_BITS);
                  if (d > 0) begin
                     hit = 0;
                     break;
                  end
                  if (bi < 0 || d > best) begin
                     best = d;
                     bi = i;
                  end
               end
               if (hit) begin
                  df = round_shift(best, NRM_BITS);
                  r.push_x = 32'(clamp32(round_shift(df * nrm_x[bi], NRM_BITS)));
                  r.push_y = 32'(clamp32(round_shift(df * nrm_y[bi], NRM_BITS)));
               end
            end
         end
         OP_RAY: begin
            for (int i = 0; i < 4; i++) begin
               j = i < 2 ? 2 : 0;
               qd = along_normal(dx, dy, i);
               aq = qd < 0 ? longint'(0) - qd : qd;
               if (aq < NEAR_ZERO) continue;
               num = along_normal(ept_x[i] - px, ept_y[i] - py, i);
               if (num != 0 && ((num < 0) != (qd < 0))) continue;
               an = num < 0 ? longint'(0) - num : num;
               t = hit_time(an, aq);
               lx = step_along(px, t, dx);
               ly = step_along(py, t, dy);
               if (lx > FAR_EDGE || lx < -FAR_EDGE || ly > FAR_EDGE || ly < -FAR_EDGE)
                  continue;
               if (along_normal(lx - ept_x[j], ly - ept_y[j], j) > 0 ||
                   along_normal(lx - ept_x[j + 1], ly - ept_y[j + 1], j + 1) > 0)
                  continue;
               if (!hit || t < near_t) begin
                  near_t = t;
                  hit = 1;
               end
            end
         end
         default: ;
      endcase
      r.hit = hit;
      r.ray_distance = near_t[31:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      mismatches++;
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
   endtask

   // result checker
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result with no item waiting", 1, 0);
         end else begin
            want = expected_results.pop_front();
            results_checked++;
            if (rsp_hit !== want.hit) report_mismatch("hit", rsp_hit, want.hit);
            if (rsp_push_x !== want.push_x) report_mismatch("push_x", rsp_push_x, want.push_x);
            if (rsp_push_y !== want.push_y) report_mismatch("push_y", rsp_push_y, want.push_y);
            if (rsp_ray_distance !== want.ray_distance)
               report_mismatch("ray_distance", rsp_ray_distance, want.ray_distance);
         end
      end
   end

   // watchdog on cycles with no traffic
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || psel) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > IDLE_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", expected_results.size());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   task automatic send_query(item_type q);
      start <= 1'b1;
      req_operation <= q.operation;
      req_pos_x <= q.pos_x;
      req_pos_y <= q.pos_y;
      req_radius <= q.radius;
      req_dir_x <= q.dir_x;
      req_dir_y <= q.dir_y;
      @(negedge clock);
      while (busy) @(negedge clock);
      expected_results.push_back(predict_query(q));
      items_sent++;
      @(posedge clock);
   endtask

   task automatic hold_off(int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic int random_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_gaps || roll < 65) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(20, 60);
   endfunction

   task automatic drain();
      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_box_reg(logic [2:0] idx, logic [31:0] value);
      drain();
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= 5'(idx) << 2;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         REG_HALF_WIDTH, REG_HALF_HEIGHT: box_reg[idx] = {1'b0, value[30:0]};
         REG_FACING_SIN, REG_FACING_COS: box_reg[idx] = {16'd0, value[15:0]};
         default: box_reg[idx] = value;
      endcase
      rebuild_geometry();
      setups_used++;
      @(posedge clock);
   endtask

   task automatic set_box(logic [31:0] cx, logic [31:0] cy, logic [31:0] hw, logic [31:0] hh,
                          logic [31:0] s, logic [31:0] c);
      write_box_reg(REG_CENTER_X, cx);
      write_box_reg(REG_CENTER_Y, cy);
      write_box_reg(REG_HALF_WIDTH, hw);
      write_box_reg(REG_HALF_HEIGHT, hh);
      write_box_reg(REG_FACING_SIN, s);
      write_box_reg(REG_FACING_COS, c);
   endtask

   function automatic item_type make_query(logic [1:0] op, longint px, longint py,
                                           longint rad, longint dx, longint dy);
      item_type q;
      q.operation = op;
      q.pos_x = 32'(px); q.pos_y = 32'(py);
      q.radius = 31'(rad);
      q.dir_x = 32'(dx); q.dir_y = 32'(dy);
      return q;
   endfunction

   // mostly near the box so edge tests matter, sometimes anywhere
   function automatic item_type random_query();
      longint span, cx, cy;
      int roll;
      item_type q;
      roll = $urandom_range(0, 99);
      cx = longint'($signed(box_reg[REG_CENTER_X]));
      cy = longint'($signed(box_reg[REG_CENTER_Y]));
      span = longint'(box_reg[REG_HALF_WIDTH]) + longint'(box_reg[REG_HALF_HEIGHT]) + 4;
      if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
      q = make_query(2'($urandom_range(0, 2)),
                     cx + longint'($urandom_range(0, 32'(2 * span))) - span - span / 4,
                     cy + longint'($urandom_range(0, 32'(2 * span))) - span - span / 4,
                     longint'($urandom_range(0, 32'(span / 2))),
                     longint'($signed($urandom_range(0, 32'h0006_0000) - 32'h0003_0000)),
                     longint'($signed($urandom_range(0, 32'h0006_0000) - 32'h0003_0000)));
      if (roll < 4) q.operation = OP_UNUSED;
      if (roll >= 90) begin
         q.operation = 2'($urandom);
         q.pos_x = $urandom; q.pos_y = $urandom; q.radius = 31'($urandom);
         q.dir_x = $urandom; q.dir_y = $urandom;
      end
      return q;
   endfunction

   task automatic random_box();
      real a;
      int roll;
      logic [31:0] hw, hh;
      roll = $urandom_range(0, 9);
      a = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
      hw = $urandom_range(1, 32'h0040_0000);
      hh = $urandom_range(1, 32'h0040_0000);
      if (roll == 0) begin
         set_box($urandom, $urandom, 32'($urandom), 32'($urandom), $urandom, $urandom);
      end else begin
         set_box($urandom_range(0, 32'h0200_0000) - 32'h0100_0000,
                 $urandom_range(0, 32'h0200_0000) - 32'h0100_0000, hw, hh,
                 32'($rtoi($sin(a) * 16384.0)), 32'($rtoi($cos(a) * 16384.0)));
      end
   endtask

   task automatic test_point_queries();
      set_box(32'h0001_0000, 32'hFFFE_0000, 32'h0003_0000, 32'h0002_0000, 32'd0, 32'd16384);
      send_query(make_query(OP_POINT, 64'h1_0000, -64'h2_0000, 0, 0, 0));
      send_query(make_query(OP_POINT, 64'h4_0000, 0, 0, 0, 0));
      send_query(make_query(OP_POINT, -64'h2_0000, -64'h4_0000, 0, 0, 0));
      send_query(make_query(OP_POINT, 64'h4_0001, 0, 0, 0, 0));
      send_query(make_query(OP_POINT, 64'sh7FFF_FFFF, -64'sh8000_0000, 0, 0, 0));
   endtask

   task automatic test_circle_queries();
      send_query(make_query(OP_CIRCLE, 64'h1_0000, -64'h2_0000, 0, 0, 0));
      send_query(make_query(OP_CIRCLE, 64'h5_0000, 0, 64'h1_8000, 0, 0));
      send_query(make_query(OP_CIRCLE, 64'h6_0000, 0, 64'h1_0000, 0, 0));
      send_query(make_query(OP_CIRCLE, 0, 0, 64'h7FFF_FFFF, 0, 0));
      send_query(make_query(OP_CIRCLE, -64'sh8000_0000, 64'sh7FFF_FFFF, 64'h7FFF_FFFF, 0, 0));
   endtask

   task automatic test_ray_queries();
      // zero and near-perpendicular directions skip edges
      send_query(make_query(OP_RAY, -64'h8_0000, -64'h2_0000, 0, 0, 0));
      send_query(make_query(OP_RAY, -64'h8_0000, -64'h2_0000, 0, 1, 0));
      send_query(make_query(OP_RAY, -64'h8_0000, -64'h2_0000, 0, 64'h1_0000, 0));
      send_query(make_query(OP_RAY, 64'h1_0000, -64'h2_0000, 0, 0, -64'h1_0000));
      send_query(make_query(OP_RAY, -64'h8_0000, -64'h2_0000, 0, -64'h1_0000, 0));
      send_query(make_query(OP_RAY, -64'sh8000_0000, -64'h2_0000, 0, 1024, 0));
      send_query(make_query(OP_RAY, -64'h8_0000, -64'h2_0000, 0,
                            64'sh7FFF_FFFF, -64'sh8000_0000));
   endtask

   task automatic test_unused_operation();
      send_query(make_query(OP_UNUSED, 0, 0, 64'h7FFF_FFFF, 64'h1_0000, 64'h1_0000));
   endtask

   task automatic test_register_extremes();
      set_box(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'hFFFF_C000, 32'h0000_4000);
      send_query(make_query(OP_POINT, 64'sh7FFF_FFFF, -64'sh8000_0000, 0, 0, 0));
      send_query(make_query(OP_CIRCLE, 0, 0, 64'h7FFF_FFFF, 0, 0));
      send_query(make_query(OP_RAY, 0, 0, 0, 64'h1_0000, 64'h1_0000));
      // values beyond one in the facing registers
      set_box(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'h0000_8000, 32'h0000_7FFF);
      send_query(make_query(OP_POINT, -64'sh8000_0000, 64'sh7FFF_FFFF, 0, 0, 0));
      send_query(make_query(OP_CIRCLE, -64'sh8000_0000, 64'sh7FFF_FFFF, 64'h100, 0, 0));
      send_query(make_query(OP_RAY, 0, 0, 0, -64'sh8000_0000, 64'sh7FFF_FFFF));
   endtask

   task automatic test_random_queries(int phases, int per_phase);
      for (int p = 0; p < phases; p++) begin
         random_box();
         no_gaps = (p % 4 == 1);
         for (int k = 0; k < per_phase; k++) begin
            send_query(random_query());
            if (k == per_phase / 2) drain();
            hold_off(random_gap());
         end
      end
   endtask

   initial begin
      box_reg[REG_CENTER_X] = 0;
      box_reg[REG_CENTER_Y] = 0;
      box_reg[REG_HALF_WIDTH] = 0;
      box_reg[REG_HALF_HEIGHT] = 0;
      box_reg[REG_FACING_SIN] = 0;
      box_reg[REG_FACING_COS] = 32'd16384;
      rebuild_geometry();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_point_queries();
      test_circle_queries();
      test_ray_queries();
      test_unused_operation();
      test_register_extremes();
      test_random_queries(10, 188);
      drain();
      repeat (200) @(posedge clock);
      $display("covered %0d items over %0d register writes, %0d results checked",
               items_sent, setups_used, results_checked);
      $display("point, circle, ray and unused queries on random and extreme boxes");
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, expected_results.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
design/obq_pkg.sv
design/obq_csr.sv
design/obq_front.sv
design/obq_div.sv
design/obq_back.sv
design/oriented_box_query_engine.sv
tb/sv/tb_oriented_box_query_engine.sv
